>>> rtl/sorted_top_k_insert_table_defines.svh
// ----------------------------------------------------------------------------
// sorted_top_k_insert_table_defines
// Assertion macros shared by the checker of the top-K table.
// ----------------------------------------------------------------------------
`ifndef SORTED_TOP_K_INSERT_TABLE_DEFINES_SVH
`define SORTED_TOP_K_INSERT_TABLE_DEFINES_SVH

// Check a same-cycle implication on the rising edge of clk, outside reset.
`define STKIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle on the rising edge of clk, outside reset.
`define STKIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/stkit_pkg.sv
// ----------------------------------------------------------------------------
// stkit_pkg
// Types, command codes and reset contents of the top-K table.
// ----------------------------------------------------------------------------
package stkit_pkg;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 4;
  localparam int POS_W   = 4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // One stored record
  typedef struct packed {
    logic [DATA_W-1:0] score;
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] tm;
  } rec_t;

  // Reset score of a slot: 1000 - 100*slot, floored at zero
  function automatic logic [DATA_W-1:0] init_score(input int unsigned slot);
    int unsigned drop;
    drop = 100 * slot;
    return (drop >= 1000) ? '0 : DATA_W'(1000 - drop);
  endfunction

  // Reset time of a slot: 300 + 60*slot
  function automatic logic [DATA_W-1:0] init_time(input int unsigned slot);
    return DATA_W'(300 + 60 * slot);
  endfunction

endpackage

>>> rtl/stkit_if.sv
// ----------------------------------------------------------------------------
// stkit_if
// Command and result channels of the top-K table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stkit_req_if import stkit_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [DATA_W-1:0]  score;
  logic [DATA_W-1:0]  level;
  logic [DATA_W-1:0]  duration;
  logic [INDEX_W-1:0] index;

  modport source (output valid, cmd, score, level, duration, index, input ready);
  modport sink   (input valid, cmd, score, level, duration, index, output ready);
endinterface

interface stkit_rsp_if import stkit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] out_score;
  logic [DATA_W-1:0] out_level;
  logic [DATA_W-1:0] out_time;
  logic [POS_W-1:0]  valid_count;

  modport source (output valid, ok, position, out_score, out_level, out_time, valid_count,
                  input ready);
  modport sink   (input valid, ok, position, out_score, out_level, out_time, valid_count,
                  output ready);
endinterface

>>> rtl/sorted_top_k_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_top_k_insert_table
// Descending top-K table of (score, level, time) records with a valid count.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per item: insert (score, level, duration),
//   read (index) or clear. rsp returns exactly one result item per command:
//   ok, position, read data and the valid count after the command.
//   Each slot is a cell that compares its score with the incoming one; all
//   cells decide in the same cycle and shift records down to their neighbor.
//   Latency: the result is in the rsp register the cycle after acceptance.
//   Throughput: one item per cycle while rsp is taken every cycle.
//   Stall: req.ready drops only while a result waits in rsp and rsp.ready is
//   low; the next command is taken in the same cycle the result leaves.
//   Reset: rst (synchronous) loads slot i with score 1000-100*i floored at 0,
//   level 1, time 300+60*i, and sets the count to SLOTS; rsp is emptied.
// ----------------------------------------------------------------------------
module sorted_top_k_insert_table import stkit_pkg::*; #(
  parameter int SLOTS = 10
) (
  input logic         clk,
  input logic         rst,
  stkit_req_if.sink   req,
  stkit_rsp_if.source rsp
);

  localparam int CW = $clog2(SLOTS + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [SLOTS-1:0] q;
  rec_t             recs [SLOTS];
  rec_t             new_rec;
  logic             accept;
  logic             do_insert;
  logic             found;
  logic [POS_W-1:0] pos;
  logic             rd_ok;
  rec_t             rd_rec;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign do_insert = accept && (req.cmd == CMD_INSERT);

  assign new_rec.score = req.score;
  assign new_rec.level = req.level;
  assign new_rec.tm    = req.duration;

  // Row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      stkit_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk(clk), .rst(rst), .insert(do_insert), .new_rec(new_rec), .count(count),
        .prev_q(1'b0), .prev_rec(new_rec), .q(q[i]), .rec(recs[i])
      );
    end else begin : g_body
      stkit_cell #(.IDX(i), .CW(CW)) u_cell (
        .clk(clk), .rst(rst), .insert(do_insert), .new_rec(new_rec), .count(count),
        .prev_q(q[i-1]), .prev_rec(recs[i-1]), .q(q[i]), .rec(recs[i])
      );
    end
  end

  // Find the insert position: lowest qualifying slot
  always_comb begin
    found = |q;
    pos   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (q[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  // Select the read slot
  always_comb begin
    rd_rec = '0;
    rd_ok  = (32'(req.index) < 32'(count)) && (32'(req.index) < SLOTS);
    for (int i = 0; i < SLOTS; i++) begin
      if (req.index == INDEX_W'(i)) begin
        rd_rec = recs[i];
      end
    end
  end

  // Advance the count
  always_comb begin
    count_next = count;
    if (accept) begin
      unique case (req.cmd)
        CMD_INSERT: begin
          if (found && (32'(count) < SLOTS)) begin
            count_next = count + CW'(1);
          end
        end
        CMD_CLEAR: count_next = '0;
        default:   count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(SLOTS);
    end else begin
      count <= count_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.ok          <= 1'b0;
      rsp.position    <= '0;
      rsp.out_score   <= '0;
      rsp.out_level   <= '0;
      rsp.out_time    <= '0;
      rsp.valid_count <= POS_W'({{POS_W{1'b0}}, count_next});
      unique case (req.cmd)
        CMD_INSERT: begin
          rsp.ok       <= found;
          rsp.position <= found ? pos : '0;
        end
        CMD_READ: begin
          rsp.ok <= rd_ok;
          if (rd_ok) begin
            rsp.out_score <= rd_rec.score;
            rsp.out_level <= rd_rec.level;
            rsp.out_time  <= rd_rec.tm;
          end
        end
        default: begin
          rsp.ok <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/stkit_cell.sv
// ----------------------------------------------------------------------------
// stkit_cell
// One slot of the table: compares against the new score and shifts down.
// ----------------------------------------------------------------------------
module stkit_cell import stkit_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          insert,
  input  rec_t          new_rec,
  input  logic [CW-1:0] count,
  input  logic          prev_q,
  input  rec_t          prev_rec,
  output logic          q,
  output rec_t          rec
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  // Slot takes a new record if it is unused or beaten by the new score
  assign q = (IDX_C >= count) || (new_rec.score > rec.score);

  // Load the new record at the first qualifying slot, shift below it
  always_ff @(posedge clk) begin
    if (rst) begin
      rec.score <= init_score(IDX);
      rec.level <= DATA_W'(1);
      rec.tm    <= init_time(IDX);
    end else if (insert && q) begin
      rec <= prev_q ? prev_rec : new_rec;
    end
  end

endmodule

>>> rtl/stkit_check.sv
// ----------------------------------------------------------------------------
// stkit_check
// Port-level checks of the top-K table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_top_k_insert_table_defines.svh"

module stkit_check import stkit_pkg::*; #(
  parameter int SLOTS = 10
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              ok,
  input logic [POS_W-1:0]  position,
  input logic [DATA_W-1:0] out_score,
  input logic [DATA_W-1:0] out_level,
  input logic [DATA_W-1:0] out_time,
  input logic [POS_W-1:0]  valid_count
);

  // A stalled result keeps its ok flag, position, valid count and score
  `STKIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(ok) && $stable(position) && $stable(valid_count) && $stable(out_score), "stalled result changed")

  // Every accepted command yields a result in the next cycle
  `STKIT_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid, "accepted item gave no result")

  // A result that leaves with no new command empties the output
  `STKIT_ASSERT_NEXT(a_rsp_drains, rsp_valid && rsp_ready && !(req_valid && req_ready), !rsp_valid, "result repeated")

  // A failed command reports no position and no data
  `STKIT_ASSERT_NOW(a_fail_zero, rsp_valid && !ok, position == '0 && out_score == '0 && out_level == '0 && out_time == '0, "failed command carried data")

endmodule

bind sorted_top_k_insert_table stkit_check #(.SLOTS(SLOTS)) u_stkit_check (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .ok(rsp.ok), .position(rsp.position),
  .out_score(rsp.out_score), .out_level(rsp.out_level), .out_time(rsp.out_time),
  .valid_count(rsp.valid_count)
);

>>> sim/stkit_table_checker.sv
// ----------------------------------------------------------------------------
// stkit_table_checker
// Watches the command and result channels of the top-K table, keeps its own
// copy of the sorted records and the entry count, predicts one result per
// accepted command and compares every accepted result with the oldest one.
// ----------------------------------------------------------------------------
module stkit_table_checker import stkit_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic clk,
  input  logic rst,
  stkit_req_if req,
  stkit_rsp_if rsp,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              ok;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] score;
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] tm;
    logic [POS_W-1:0]  count;
  } outcome_t;

  logic [DATA_W-1:0] rank_score [SLOTS];
  logic [DATA_W-1:0] rank_level [SLOTS];
  logic [DATA_W-1:0] rank_time  [SLOTS];
  int                live_entries;
  outcome_t          outcome_q [$];
  int                n_fail = 0;

  initial begin
    fails   = 0;
    pending = 0;
  end

  // Load the table contents that follow reset
  function automatic void load_reset_table();
    for (int i = 0; i < SLOTS; i++) begin
      rank_score[i] = (100 * i >= 1000) ? '0 : DATA_W'(1000 - 100 * i);
      rank_level[i] = DATA_W'(1);
      rank_time[i]  = DATA_W'(300 + 60 * i);
    end
    live_entries = SLOTS;
  endfunction

  // Apply one command to the table copy and return the result it must give
  function automatic outcome_t apply_command(input logic [CMD_W-1:0]   c,
                                             input logic [DATA_W-1:0]  sc,
                                             input logic [DATA_W-1:0]  lv,
                                             input logic [DATA_W-1:0]  tsec,
                                             input logic [INDEX_W-1:0] idx);
    outcome_t o;
    int       slot;
    o    = '0;
    slot = -1;
    case (c)
      CMD_INSERT: begin
        // first slot past the count or strictly beaten; ties land below
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && (i >= live_entries || sc > rank_score[i])) slot = i;
        end
        if (slot >= 0) begin
          for (int j = SLOTS - 1; j > slot; j--) begin
            rank_score[j] = rank_score[j-1];
            rank_level[j] = rank_level[j-1];
            rank_time[j]  = rank_time[j-1];
          end
          rank_score[slot] = sc;
          rank_level[slot] = lv;
          rank_time[slot]  = tsec;
          if (live_entries < SLOTS) live_entries++;
          o.ok       = 1'b1;
          o.position = POS_W'(slot);
        end
      end
      CMD_READ: begin
        if (int'(idx) < live_entries && int'(idx) < SLOTS) begin
          o.ok    = 1'b1;
          o.score = rank_score[idx];
          o.level = rank_level[idx];
          o.tm    = rank_time[idx];
        end
      end
      CMD_CLEAR: begin
        live_entries = 0;
      end
      default: begin
      end
    endcase
    o.count = POS_W'(live_entries);
    return o;
  endfunction

  // Count a failure, print only the first few
  function automatic void flag(input string what, input outcome_t want, input outcome_t got);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t %s: exp ok=%0b pos=%0d score=%h level=%h time=%h count=%0d | act ok=%0b pos=%0d score=%h level=%h time=%h count=%0d",
               $realtime, what, want.ok, want.position, want.score, want.level, want.tm,
               want.count, got.ok, got.position, got.score, got.level, got.tm, got.count);
  endfunction

  // Predict on each accepted command, compare on each accepted result
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      load_reset_table();
      outcome_q.delete();
    end else begin
      if (req.valid && req.ready)
        outcome_q.push_back(apply_command(req.cmd, req.score, req.level,
                                          req.duration, req.index));
      if (rsp.valid && rsp.ready) begin
        got.ok       = rsp.ok;
        got.position = rsp.position;
        got.score    = rsp.out_score;
        got.level    = rsp.out_level;
        got.tm       = rsp.out_time;
        got.count    = rsp.valid_count;
        if (outcome_q.size() == 0) begin
          flag("result with nothing pending", '0, got);
        end else begin
          want = outcome_q.pop_front();
          if (want.ok !== got.ok || want.position !== got.position ||
              want.score !== got.score || want.level !== got.level ||
              want.tm !== got.tm || want.count !== got.count)
            flag("result mismatch", want, got);
        end
      end
    end
    fails   <= n_fail;
    pending <= outcome_q.size();
  end

endmodule

>>> sim/tb_sorted_top_k_insert_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_top_k_insert_table
// Drives the top-K table with directed commands (reset contents, extremes,
// ties, rejects, clears, reads past the count, the unused code) and then
// random command streams, with random idle bursts on both channels. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_top_k_insert_table;
  timeunit 1ns;
  timeprecision 1ps;
  import stkit_pkg::*;

  localparam int               SLOTS        = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int               RANDOM_ITEMS = 400;
  localparam int               CALM_START   = 150;
  localparam int               CALM_STOP    = 200;
  localparam int               QUIET_TAIL   = 60;

  logic clk;
  logic rst;
  logic calm;
  int   fails;
  int   pending;

  stkit_req_if req ();
  stkit_rsp_if rsp ();

  sorted_top_k_insert_table #(.SLOTS(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  stkit_table_checker #(.SLOTS(SLOTS)) table_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .fails   (fails),
    .pending (pending)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: stall in short bursts unless calm
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  // Present one command item and hold it until the block takes it
  task automatic send(input logic [CMD_W-1:0]   c,
                      input logic [DATA_W-1:0]  sc,
                      input logic [DATA_W-1:0]  lv,
                      input logic [DATA_W-1:0]  tsec,
                      input logic [INDEX_W-1:0] idx);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.cmd      <= c;
    req.score    <= sc;
    req.level    <= lv;
    req.duration <= tsec;
    req.index    <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Random command: inserts dominate so the table refills after clears
  task automatic send_random();
    logic [CMD_W-1:0]  c;
    logic [DATA_W-1:0] sc;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 58)      c = CMD_INSERT;
    else if (pick < 90) c = CMD_READ;
    else if (pick < 96) c = CMD_CLEAR;
    else                c = CMD_UNUSED;
    // scores on the reset grid and in narrow ranges force ties and rejects
    case ($urandom_range(0, 4))
      0:       sc = $urandom();
      1:       sc = DATA_W'($urandom_range(0, 12) * 100);
      2:       sc = DATA_W'($urandom_range(0, 1200));
      3:       sc = $urandom_range(0, 1) ? '1 : '0;
      default: sc = DATA_W'($urandom_range(0, 64));
    endcase
    send(c, sc, $urandom(), $urandom(), INDEX_W'($urandom_range(0, 15)));
  endtask

  // Stimulus and verdict
  initial begin
    rst           = 1'b1;
    calm          = 1'b0;
    req.valid    <= 1'b0;
    req.cmd      <= CMD_INSERT;
    req.score    <= '0;
    req.level    <= '0;
    req.duration <= '0;
    req.index    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // read reset contents, last valid slot, past the table, top index
    send(CMD_READ, '0, '0, '0, 4'd0);
    send(CMD_READ, '0, '0, '0, 4'd9);
    send(CMD_READ, '0, '0, '0, 4'd10);
    send(CMD_READ, '1, '1, '1, 4'd15);
    // top score, tie goes below, a reject on a full table, last-slot insert
    send(CMD_INSERT, '1, '1, '1, 4'd0);
    send(CMD_INSERT, DATA_W'(1000), DATA_W'(7), DATA_W'(11), 4'd0);
    send(CMD_INSERT, '0, '0, '0, 4'd0);
    send(CMD_INSERT, DATA_W'(301), DATA_W'(3), DATA_W'(5), 4'd0);
    send(CMD_READ, '0, '0, '0, 4'd9);
    // unused code and clear with busy fields
    send(CMD_UNUSED, '1, '1, '1, 4'd15);
    send(CMD_CLEAR, '1, '1, '1, 4'd15);
    send(CMD_READ, '0, '0, '0, 4'd0);
    // refill from empty: zero score accepted, tie below, new best
    send(CMD_INSERT, '0, DATA_W'(1), DATA_W'(2), 4'd0);
    send(CMD_INSERT, '0, DATA_W'(3), DATA_W'(4), 4'd0);
    send(CMD_INSERT, DATA_W'(1), '1, '0, 4'd0);
    send(CMD_READ, '0, '0, '0, 4'd2);
    send(CMD_READ, '0, '0, '0, 4'd3);
    // overfill so the lowest entry drops
    for (int i = 0; i < 8; i++)
      send(CMD_INSERT, DATA_W'(i * 7), $urandom(), $urandom(), 4'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= CALM_START && n < CALM_STOP) || (n >= RANDOM_ITEMS - QUIET_TAIL);
      send_random();
    end
    req.valid <= 1'b0;

    // drain, then allow for the result register
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
